[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define SSR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `SSR_ASSERT_IMPLY(lbl, clk, rst_n, 1'b1, !(cond), msg)

`endif

[rtl/core/ssr_pkg.sv]
`timescale 1ns / 1ps

package ssr_pkg;

    localparam int CMD_BYTES  = 8;                  // hard cap on pattern/replacement bytes
    localparam int IDX_W      = $clog2(CMD_BYTES);
    localparam int LEN_W      = 4;
    localparam int CNT_W      = 31;
    localparam int MAX_W      = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES     = 3'd0,
        CFG_PATTERN_LENGTH    = 3'd1,
        CFG_REPLACE_BYTES     = 3'd2,
        CFG_REPLACE_LENGTH    = 3'd3,
        CFG_MAX_REPLACEMENTS  = 3'd4
    } t_cfg_index;

    // One burst of output items produced by one input item.
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] data;
        logic [LEN_W-1:0]          count;   // zero with last set: bare end marker
        logic                      last;
    } t_cmd;

endpackage

[rtl/core/ssr_ifs.sv]
`timescale 1ns / 1ps

interface ssr_in_if;
    import ssr_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       in_last;

    modport source (output valid, output in_byte, output byte_present, output in_last,
                    input ready);
    modport sink   (input valid, input in_byte, input byte_present, input in_last,
                    output ready);
endinterface

interface ssr_out_if;
    import ssr_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_present;
    logic       out_last;

    modport source (output valid, output out_byte, output out_present, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_present, input out_last,
                    output ready);
endinterface

interface ssr_cfg_if;
    import ssr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/core/ssr_cmd_fifo.sv]
`timescale 1ns / 1ps

module ssr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ssr_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import ssr_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(Q_DEPTH));

endmodule

[rtl/core/ssr_front.sv]
`timescale 1ns / 1ps

module ssr_front #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssr_in_if.sink        i_in,
    ssr_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output ssr_pkg::t_cmd o_cmd
);
    import ssr_pkg::*;

    localparam int WIN  = (PATTERN_MAX < CMD_BYTES) ? PATTERN_MAX : CMD_BYTES;
    localparam int RWIN = (REPLACE_MAX < CMD_BYTES) ? REPLACE_MAX : CMD_BYTES;
    localparam int FW   = $clog2(WIN + 1);
    localparam logic [LEN_W-1:0] WIN_LEN  = LEN_W'(WIN);
    localparam logic [LEN_W-1:0] RWIN_LEN = LEN_W'(RWIN);

    // configuration
    logic [CFG_DATA_W-1:0]   r_pat, r_rep;
    logic [LEN_W-1:0]        r_plen, r_rlen;
    logic signed [MAX_W-1:0] r_max;

    // string state
    logic [7:0]       r_win [WIN];
    logic [FW-1:0]    r_fill;
    logic [CNT_W-1:0] r_cnt;

    logic [7:0]       wp [WIN];
    logic [7:0]       n_win [WIN];
    logic [FW-1:0]    fillp, n_fill;
    logic [CNT_W-1:0] n_cnt;
    logic [LEN_W-1:0] plen, rlen;
    logic             accept, push_ok, allowed, try_match, eq, do_match, pop;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && i_in.ready;

    assign plen = (r_plen > WIN_LEN)  ? WIN_LEN  : r_plen;
    assign rlen = (r_rlen > RWIN_LEN) ? RWIN_LEN : r_rlen;

    assign allowed = (plen != '0) && (r_max != '0) &&
                     (r_max[MAX_W-1] || (r_cnt < r_max[CNT_W-1:0]));

    assign push_ok = i_in.byte_present && (r_fill < FW'(WIN));
    assign fillp   = r_fill + FW'(push_ok);

    // window with the incoming byte appended
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            wp[i] = (push_ok && (FW'(i) == r_fill)) ? i_in.in_byte : r_win[i];
        end
    end

    always_comb begin
        eq = 1'b1;
        for (int i = 0; i < WIN; i++) begin
            eq = eq && ((LEN_W'(i) >= plen) || (wp[i] == r_pat[8*i +: 8]));
        end
    end

    assign try_match = i_in.byte_present && allowed && (LEN_W'(fillp) == plen);
    assign do_match  = try_match && eq;
    assign pop       = i_in.byte_present && !do_match &&
                       (try_match || !allowed || (LEN_W'(fillp) > plen));

    // burst description for the back end
    always_comb begin
        o_cmd.last = i_in.in_last;
        if (do_match) begin
            o_cmd.data  = r_rep;
            o_cmd.count = rlen;
        end else begin
            o_cmd.data = '0;
            for (int i = 0; i < WIN; i++) begin
                o_cmd.data[i] = wp[i];
            end
            if (i_in.in_last) begin
                o_cmd.count = LEN_W'(fillp);
            end else begin
                o_cmd.count = pop ? LEN_W'(1) : '0;
            end
        end
    end

    assign o_push = accept && (i_in.in_last || (o_cmd.count != '0));

    always_comb begin
        n_win  = wp;
        n_fill = fillp;
        n_cnt  = r_cnt;
        if (i_in.in_last) begin
            n_fill = '0;
            n_cnt  = '0;
        end else if (do_match) begin
            n_fill = '0;
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (pop) begin
            for (int i = 0; i < WIN - 1; i++) begin
                n_win[i] = wp[i+1];
            end
            n_fill = fillp - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
            r_max  <= '1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.reg_index)
                CFG_PATTERN_BYTES:    r_pat  <= i_cfg.wdata;
                CFG_PATTERN_LENGTH:   r_plen <= i_cfg.wdata[LEN_W-1:0];
                CFG_REPLACE_BYTES:    r_rep  <= i_cfg.wdata;
                CFG_REPLACE_LENGTH:   r_rlen <= i_cfg.wdata[LEN_W-1:0];
                CFG_MAX_REPLACEMENTS: r_max  <= i_cfg.wdata[MAX_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/ssr_back.sv]
`timescale 1ns / 1ps

module ssr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssr_pkg::t_cmd i_head,
    input  logic          i_head_valid,
    output logic          o_pop,
    ssr_out_if.source     o_out
);
    import ssr_pkg::*;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte;
    logic             r_present, r_last;

    logic [LEN_W-1:0] n_items;
    logic             load, fin;

    assign n_items = (i_head.count == '0) ? LEN_W'(1) : i_head.count;
    assign fin     = (LEN_W'(r_idx) == (n_items - LEN_W'(1)));
    assign load    = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop   = load && fin;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = fin ? '0 : r_idx + 1'b1;
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // bare end marker carries a zero byte
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= (i_head.count != '0) ? i_head.data[r_idx] : 8'h00;
            r_present <= (i_head.count != '0);
            r_last    <= i_head.last && fin;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.out_present = r_present;
    assign o_out.out_last    = r_last;

endmodule

[rtl/core/substring_replace_stream.sv]
// Accepted items are queued as bursts; the back end loads result items into an output register.
// Throughput: one input item per cycle while the burst queue is not full; an item that yields k
//   result items sends them in turn; a four-entry burst queue lets input run ahead meanwhile.
// Reset (i_rst_n low, synchronous): window, counter and queue empty, registers to
//   their defaults (lengths and bytes zero, replacement limit unlimited).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module substring_replace_stream #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssr_in_if.sink    i_in,
    ssr_cfg_if.sink   i_cfg,
    ssr_out_if.source o_out
);
    import ssr_pkg::*;

    t_cmd q_cmd, q_head;
    logic q_push, q_pop, q_full, q_empty;

    ssr_front #(
        .PATTERN_MAX(PATTERN_MAX),
        .REPLACE_MAX(REPLACE_MAX)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_cmd)
    );

    ssr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ssr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (!q_empty),
        .o_pop        (q_pop),
        .o_out        (o_out)
    );

    `SSR_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, q_push && q_full,
        "burst pushed into full queue")
    `SSR_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, q_pop && q_empty,
        "burst popped from empty queue")
    `SSR_ASSERT_IMPLY(a_bare_end, i_clk, i_rst_n, o_out.valid && !o_out.out_present,
        o_out.out_last, "bare item without last")

endmodule
